// ===== design/b64c_pkg.sv =====
// Shared types, constants and alphabet helpers for the Base64 stream codec.
// No dependencies; every other file imports this package.
package b64c_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] CFG_DECODE_MODE  = 2'd0;
  localparam logic [1:0] CFG_URL_ALPHABET = 2'd1;
  localparam logic [1:0] CFG_KEEP_PAD     = 2'd2;

  typedef struct packed {
    logic decode_mode;
    logic url_alphabet;
    logic keep_pad;
  } cfg_t;

  // One finished group: up to four result beats, cnt is 1 to 4
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
  } job_t;

  // Map a 6-bit value to its alphabet character
  function automatic logic [7:0] sym_of(input logic [5:0] v, input logic url);
    logic [7:0] s;
    if (v < 6'd26) begin
      s = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      s = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      s = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      s = url ? 8'h2D : 8'h2B;
    end else begin
      s = url ? 8'h5F : 8'h2F;
    end
    return s;
  endfunction

  // Map a character back to its value; pad reads as zero, unknown as 255
  function automatic logic [7:0] val_of(input logic [7:0] c, input logic url);
    logic [7:0] v;
    if (c == PAD_CHAR) begin
      v = 8'd0;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if ((!url && c == 8'h2B) || (url && c == 8'h2D)) begin
      v = 8'd62;
    end else if ((!url && c == 8'h2F) || (url && c == 8'h5F)) begin
      v = 8'd63;
    end else begin
      v = 8'd255;
    end
    return v;
  endfunction

endpackage

// ===== design/b64c_front.sv =====
// Front end of the Base64 codec: gathers input beats into a group and, when a
// group closes, builds the result characters or bytes as one job. Uses b64c_pkg.
module b64c_front import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg_i,
  input  logic       push_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       q_full_i,
  output logic       full_o,
  output logic       job_push_o,
  output job_t       job_o
);

  logic [3:0][7:0] buf_r, buf_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  logic [3:0][7:0] gw;
  logic [2:0]      n;
  logic            accept;
  logic            fire;
  logic [1:0]      pads;
  logic [2:0]      k_enc;
  logic [2:0]      k_dec;
  logic [2:0]      nch;
  logic [3:0][7:0] enc_ch;
  logic [3:0][7:0] dec_b;
  logic [7:0]      v0, v1, v2, v3;

  assign accept = push_i && !q_full_i;
  assign full_o = q_full_i;

  // Build the group as it stands after this beat is stored
  always_comb begin
    gw        = buf_r;
    gw[cnt_r] = byte_i;
    n         = {1'b0, cnt_r} + 3'd1;
  end

  // Encode: four characters from positions zero to two, then padding
  always_comb begin
    pads = (n >= 3'd3) ? 2'd0 : ((n == 3'd1) ? 2'd2 : 2'd1);
    enc_ch[0] = sym_of(gw[0][7:2], cfg_i.url_alphabet);
    enc_ch[1] = sym_of({gw[0][1:0], gw[1][7:4]}, cfg_i.url_alphabet);
    enc_ch[2] = sym_of({gw[1][3:0], gw[2][7:6]}, cfg_i.url_alphabet);
    enc_ch[3] = sym_of(gw[2][5:0], cfg_i.url_alphabet);
    if (pads >= 2'd2) begin
      enc_ch[2] = PAD_CHAR;
    end
    if (pads >= 2'd1) begin
      enc_ch[3] = PAD_CHAR;
    end
    if (cfg_i.url_alphabet && !cfg_i.keep_pad) begin
      k_enc = 3'd4 - {1'b0, pads};
    end else begin
      k_enc = 3'd4;
    end
  end

  // Decode: three bytes, count cut at the first pad; a pad in position zero keeps three
  always_comb begin
    v0 = val_of(gw[0], cfg_i.url_alphabet);
    v1 = val_of(gw[1], cfg_i.url_alphabet);
    v2 = val_of(gw[2], cfg_i.url_alphabet);
    v3 = val_of(gw[3], cfg_i.url_alphabet);
    dec_b[0] = {v0[5:0], v1[5:4]};
    dec_b[1] = {v1[3:0], v2[5:2]};
    dec_b[2] = {v2[1:0], 6'b000000} | v3;
    dec_b[3] = 8'd0;
    nch = {1'b0, n[1:0]};
    for (int p = 3; p >= 0; p--) begin
      if (gw[p] == PAD_CHAR) begin
        nch = 3'(p);
      end
    end
    k_dec = (nch != 3'd0) ? (nch - 3'd1) : 3'd3;
  end

  // Close the group and hand a job to the queue when it has beats
  always_comb begin
    if (cfg_i.decode_mode) begin
      fire      = (n == 3'd4) || last_i;
      job_o.data = dec_b;
      job_o.cnt  = k_dec;
    end else begin
      fire      = (n >= 3'd3) || last_i;
      job_o.data = enc_ch;
      job_o.cnt  = k_enc;
    end
    job_push_o = accept && fire && (job_o.cnt != 3'd0);
  end

  // Advance the group state; encode clears the three data positions
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      buf_nxt = gw;
      if (fire) begin
        cnt_nxt = 2'd0;
        if (!cfg_i.decode_mode) begin
          buf_nxt[0] = 8'd0;
          buf_nxt[1] = 8'd0;
          buf_nxt[2] = 8'd0;
        end
      end else begin
        cnt_nxt = n[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= 2'd0;
    end else begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/b64c_job_queue.sv =====
// Short job queue between the front and back of the Base64 codec.
// Uses b64c_pkg for the job type.
module b64c_job_queue import b64c_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t job_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t            slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            do_push, do_pop;

  assign full_o  = (fill_r == CW'(DEPTH));
  assign empty_o = (fill_r == '0);
  assign job_o   = slot_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Wrap pointers at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== design/b64c_back.sv =====
// Back end of the Base64 codec (job type from b64c_pkg): walks the head job
// one beat per cycle into a registered result stage while it is free or popped.
module b64c_back import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take;
  logic       is_end;

  assign empty_o = !out_valid_r;
  assign byte_o  = out_byte_r;
  assign last_o  = out_last_r;

  // Load the result stage when it is free or being drained
  assign take   = !out_valid_r || pop_i;
  assign is_end = ({1'b0, idx_r} == (job_i.cnt - 3'd1));

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    idx_nxt       = idx_r;
    job_pop_o     = 1'b0;
    if (take) begin
      out_valid_nxt = job_valid_i;
      if (job_valid_i) begin
        out_byte_nxt = job_i.data[idx_r];
        out_last_nxt = is_end;
        if (is_end) begin
          idx_nxt   = 2'd0;
          job_pop_o = 1'b1;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== design/base64_stream_codec_top.sv =====
// Top level of the Base64 stream codec: configuration registers, front end,
// job queue and back end. Uses b64c_pkg, b64c_front, b64c_job_queue, b64c_back.
//
//   channel  ports                                   beat taken when
//   input    push full in_byte in_last               push && !full
//   result   empty pop out_byte out_last             pop && !empty
//   config   cfg_valid cfg_ready cfg_index cfg_data  cfg_valid && cfg_ready
//
// An input beat is stored in the group register; a closing beat builds a group job
// in the same cycle that it is taken. The back end emits one result per cycle while
// pop is held, so the single result port bounds encode: a full group of three input
// beats yields four results. The first result of a group is registered in the job
// queue, then in the result stage. Input stalls (full) only while the queue holds
// DEPTH jobs. Reset is synchronous, clears the group state and config but sets keep_pad.
module base64_stream_codec_top import b64c_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_empty, q_push, q_pop;
  job_t job_in, job_head;

  // Take configuration beats at any time; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DECODE_MODE:  cfg_nxt.decode_mode  = cfg_data[0];
        CFG_URL_ALPHABET: cfg_nxt.url_alphabet = cfg_data[0];
        CFG_KEEP_PAD:     cfg_nxt.keep_pad     = cfg_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decode_mode  <= 1'b0;
      cfg_r.url_alphabet <= 1'b0;
      cfg_r.keep_pad     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  b64c_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .push_i     (push),
    .byte_i     (in_byte),
    .last_i     (in_last),
    .q_full_i   (q_full),
    .full_o     (full),
    .job_push_o (q_push),
    .job_o      (job_in)
  );

  b64c_job_queue #(.DEPTH(DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .job_i   (job_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .job_o   (job_head)
  );

  b64c_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid_i (!q_empty),
    .job_i       (job_head),
    .job_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .byte_o      (out_byte),
    .last_o      (out_last)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_job_has_beats: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (job_in.cnt != 3'd0 && job_in.cnt <= 3'd4))
    else $error("job pushed with a bad beat count");

  a_retire_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (!empty && out_last))
    else $error("job retired without its last result beat");
`endif

endmodule

// ===== sim/tb_base64_stream_codec_top.sv =====
// Self-checking testbench for base64_stream_codec_top: encode and decode beats
// are mirrored in a local codec model and every out beat is compared in order.
// Depends on b64c_pkg and the design files under design/.
module tb_base64_stream_codec_top;
  import b64c_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_BEATS = 40;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // Local copy of the codec state and registers
  logic [7:0] grp_buf [4];
  logic [1:0] grp_cnt;
  cfg_t       mdl_cfg;

  out_beat_t  beat_q [$];
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         tx_count = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;
  int         rx_hold = 0;

  string std_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string url_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  base64_stream_codec_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL base64_stream_codec_top");
      $finish;
    end
  end

  function automatic logic [7:0] sym_char(logic [5:0] v);
    return mdl_cfg.url_alphabet ? url_alpha[int'(v)] : std_alpha[int'(v)];
  endfunction

  // Pad reads as zero, anything outside the alphabet as 255
  function automatic logic [7:0] char_val(logic [7:0] c);
    logic [7:0] v;
    v = 8'd255;
    if (c == PAD_CHAR) begin
      v = 8'd0;
    end else begin
      for (int k = 0; k < 64; k++) begin
        if (sym_char(6'(k)) == c) v = 8'(k);
      end
    end
    return v;
  endfunction

  function automatic void queue_group(logic [3:0][7:0] vals, int k);
    for (int r = 0; r < k; r++) beat_q.push_back('{vals[r], (r == k - 1)});
  endfunction

  // Advance the codec model by one accepted in beat
  function automatic void codec_step(logic [7:0] b, logic last);
    logic [2:0]      n;
    logic [3:0][7:0] ch;
    logic [7:0]      v0, v1, v2, v3;
    int              pads, k, nch;
    n = {1'b0, grp_cnt} + 3'd1;
    grp_buf[grp_cnt] = b;
    if (!mdl_cfg.decode_mode) begin
      if (n < 3'd3 && !last) begin
        grp_cnt = n[1:0];
      end else begin
        pads = (n >= 3'd3) ? 0 : ((n == 3'd1) ? 2 : 1);
        ch[0] = sym_char(grp_buf[0][7:2]);
        ch[1] = sym_char({grp_buf[0][1:0], grp_buf[1][7:4]});
        ch[2] = sym_char({grp_buf[1][3:0], grp_buf[2][7:6]});
        ch[3] = sym_char(grp_buf[2][5:0]);
        if (pads >= 2) ch[2] = PAD_CHAR;
        if (pads >= 1) ch[3] = PAD_CHAR;
        k = (mdl_cfg.url_alphabet && !mdl_cfg.keep_pad) ? 4 - pads : 4;
        grp_buf[0] = 8'd0;
        grp_buf[1] = 8'd0;
        grp_buf[2] = 8'd0;
        grp_cnt = 2'd0;
        queue_group(ch, k);
      end
    end else begin
      if (n < 3'd4 && !last) begin
        grp_cnt = n[1:0];
      end else begin
        v0 = char_val(grp_buf[0]);
        v1 = char_val(grp_buf[1]);
        v2 = char_val(grp_buf[2]);
        v3 = char_val(grp_buf[3]);
        ch[0] = {v0[5:0], v1[5:4]};
        ch[1] = {v1[3:0], v2[5:2]};
        // last value is not masked, so an invalid char forces 255 here
        ch[2] = {v2[1:0], 6'd0} | v3;
        ch[3] = 8'd0;
        // first pad anywhere in the buffer, stale slots included, sets the count
        nch = int'(n[1:0]);
        for (int p = 3; p >= 0; p--) begin
          if (grp_buf[p] == PAD_CHAR) nch = p;
        end
        k = (nch > 0) ? nch - 1 : 3;
        grp_cnt = 2'd0;
        queue_group(ch, k);
      end
    end
  endfunction

  // Offer one in beat after a random idle gap; hold push high across back-to-back beats
  task automatic send_beat(logic [7:0] b, logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk); while (full);
    tx_count++;
    codec_step(b, last);
  endtask

  task automatic send_str(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], close && (i == s.len() - 1));
  endtask

  // Drop push, drain all expected beats, then give in-flight groups time to finish
  task automatic settle();
    push <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers plus the spare index, only while idle
  task automatic write_cfg(cfg_t c);
    logic [1:0] idx_list [4];
    logic [7:0] d;
    idx_list = '{CFG_DECODE_MODE, CFG_URL_ALPHABET, CFG_KEEP_PAD, CFG_SPARE_IDX};
    settle();
    foreach (idx_list[i]) begin
      d = 8'($urandom);
      case (idx_list[i])
        CFG_DECODE_MODE:  d[0] = c.decode_mode;
        CFG_URL_ALPHABET: d[0] = c.url_alphabet;
        CFG_KEEP_PAD:     d[0] = c.keep_pad;
        default: ;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data <= d;
      do @(posedge clk); while (!cfg_ready);
      case (idx_list[i])
        CFG_DECODE_MODE:  mdl_cfg.decode_mode = d[0];
        CFG_URL_ALPHABET: mdl_cfg.url_alphabet = d[0];
        CFG_KEEP_PAD:     mdl_cfg.keep_pad = d[0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte_msg(int len);
    repeat (len - 1) send_beat(8'($urandom), 1'b0);
    send_beat(8'($urandom), 1'b1);
  endtask

  // Well-formed text: full groups, then an optional padded or unpadded tail
  task automatic send_text_msg();
    logic [7:0] txt [$];
    int         ng, tail;
    ng = $urandom_range(0, 3);
    tail = $urandom_range(0, 4);
    if (tail == 0 && ng == 0) ng = 1;
    repeat (ng * 4) txt.push_back(sym_char(6'($urandom)));
    case (tail)
      1: begin
        repeat (2) txt.push_back(sym_char(6'($urandom)));
        repeat (2) txt.push_back(PAD_CHAR);
      end
      2: begin
        repeat (3) txt.push_back(sym_char(6'($urandom)));
        txt.push_back(PAD_CHAR);
      end
      3: repeat (2) txt.push_back(sym_char(6'($urandom)));
      4: repeat (3) txt.push_back(sym_char(6'($urandom)));
      default: ;
    endcase
    foreach (txt[i]) send_beat(txt[i], i == txt.size() - 1);
  endtask

  // Mix of pads, alphabet chars and raw bytes with random last marks
  task automatic send_noise(int len);
    logic [7:0] c;
    repeat (len) begin
      case ($urandom_range(0, 2))
        0:       c = PAD_CHAR;
        1:       c = sym_char(6'($urandom));
        default: c = 8'($urandom);
      endcase
      send_beat(c, $urandom_range(0, 3) == 0);
    end
  endtask

  // One full group of all ones, then a one-pad group, at reset settings
  task automatic test_encode_groups();
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
  endtask

  // URL alphabet with padding dropped: two-pad tail and the '-' '_' symbols
  task automatic test_url_unpadded();
    write_cfg(cfg_t'{decode_mode: 1'b0, url_alphabet: 1'b1, keep_pad: 1'b0});
    send_beat(8'hFB, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hEF, 1'b0);
    send_beat(8'hBE, 1'b0);
  endtask

  task automatic test_decode_cases();
    write_cfg(cfg_t'{decode_mode: 1'b1, url_alphabet: 1'b0, keep_pad: 1'b1});
    // pad in slot two truncates to one byte
    send_str("+/==", 1'b0);
    // invalid char in the last slot forces the last byte to 255
    send_str("AAA*", 1'b0);
    // short final group reads stale slots
    send_str("QQ", 1'b1);
    // pad in slot zero yields three bytes
    send_str("=", 1'b1);
  endtask

  // Group state carries over mode changes in both directions
  task automatic test_mode_carry();
    write_cfg(cfg_t'{decode_mode: 1'b0, url_alphabet: 1'b0, keep_pad: 1'b1});
    send_beat(8'h4D, 1'b0);
    send_beat(8'h61, 1'b0);
    write_cfg(cfg_t'{decode_mode: 1'b1, url_alphabet: 1'b1, keep_pad: 1'b1});
    send_str("-_", 1'b0);
    send_str("TWF", 1'b0);
    // count of three in encode: unpadded group from slots zero to two
    write_cfg(cfg_t'{decode_mode: 1'b0, url_alphabet: 1'b0, keep_pad: 1'b1});
    send_beat(8'h6E, 1'b0);
  endtask

  // Hold off the receiver while the sender keeps offering, so full asserts
  task automatic test_backpressure();
    write_cfg(cfg_t'{decode_mode: 1'b0, url_alphabet: 1'b0, keep_pad: 1'b1});
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold = 250;
    send_byte_msg(15);
    send_byte_msg(15);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Sweep every register setting with random messages
  task automatic test_random_sweep();
    int start;
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(cfg_t'(3'(ph)));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      start = tx_count;
      while (tx_count - start < PHASE_BEATS) begin
        if (mdl_cfg.decode_mode) begin
          if ($urandom_range(0, 9) < 7) send_text_msg();
          else send_noise($urandom_range(1, 6));
        end else begin
          if ($urandom_range(0, 9) < 8) send_byte_msg($urandom_range(1, 10));
          else send_noise($urandom_range(1, 4));
        end
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Out side: pop after random gaps and compare each beat with the oldest prediction
  initial begin : out_check
    int        gap, hold;
    out_beat_t want;
    pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        hold = rx_hold;
        rx_hold = 0;
        pop <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = rx_idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (beat_q.size() == 0) begin
        $error("unexpected out beat: out_byte %h out_last %b", out_byte, out_last);
        err_cnt++;
      end else begin
        want = beat_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte mismatch: expected %h actual %h", want.data, out_byte);
          err_cnt++;
        end
        if (out_last !== want.last) begin
          $error("out_last mismatch: expected %b actual %b", want.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_byte = 8'd0;
    in_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 2'd0;
    cfg_data = 8'd0;
    mdl_cfg = cfg_t'{decode_mode: 1'b0, url_alphabet: 1'b0, keep_pad: 1'b1};
    foreach (grp_buf[i]) grp_buf[i] = 8'd0;
    grp_cnt = 2'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_encode_groups();
    test_url_unpadded();
    test_decode_cases();
    test_mode_carry();
    test_backpressure();
    test_random_sweep();

    settle();
    if (err_cnt == 0) begin
      $display("PASS base64_stream_codec_top");
    end else begin
      $display("FAIL base64_stream_codec_top");
    end
    $finish;
  end

endmodule
